>>> hw/rtl/tgr_pkg.sv
// Package for the touch gesture recognizer: event and gesture codes, queue entry type.
// No dependencies.
`default_nettype none
package tgr_pkg;
    localparam int DEPTH_DEFAULT = 4;
    localparam logic [11:0] DRAG_THR_RESET = 12'd32;

    localparam logic [1:0] EV_DOWN = 2'd0;
    localparam logic [1:0] EV_MOVE = 2'd1;
    localparam logic [1:0] EV_UP   = 2'd2;

    localparam logic [2:0] G_START   = 3'd0;
    localparam logic [2:0] G_DRAG    = 3'd1;
    localparam logic [2:0] G_RELEASE = 3'd2;
    localparam logic [2:0] G_UNDO    = 3'd3;
    localparam logic [2:0] G_ZOOM    = 3'd4;
    localparam logic [2:0] G_PAN     = 3'd5;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  id;
        logic [15:0] x;
        logic [15:0] y;
    } event_t;
endpackage
`default_nettype wire

>>> hw/rtl/touch_gesture_recognizer.sv
// Top level of the touch gesture recognizer: input stage, event queue, gesture engine.
// Depends on tgr_pkg, tgr_queue, tgr_engine.
//
// Events enter through a small queue and are taken by the engine one at a time.
// In the engine a start or a release is handled in the event's execute state, a
// one-finger move also squares the distance, a second finger down adds a 17-step
// square root, and a two-finger move runs the 17-step square root then a 26-step
// divide; output stalls can hold any of these. drag_threshold may be written only
// while the block is idle.
`default_nettype none
module touch_gesture_recognizer
    import tgr_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  event_kind,
    input  wire logic [7:0]  finger_id,
    input  wire logic [15:0] pos_x,
    input  wire logic [15:0] pos_y,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       gesture_kind,
    output logic [16:0]      out_x,
    output logic [16:0]      out_y,
    output logic [15:0]      zoom_ratio,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data
);
    logic [11:0] thr_reg;
    logic full, empty, take;
    event_t wr_ev, rd_ev;

    assign cfg_ready = 1'b1;
    assign in_stall = full;
    assign wr_ev = '{kind: event_kind, id: finger_id, x: pos_x, y: pos_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= DRAG_THR_RESET;
        end
        else if (cfg_valid)
        begin
            thr_reg <= cfg_data;
        end
    end

    tgr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_en(in_valid && !full), .wr_data(wr_ev), .full(full),
        .rd_en(take), .rd_data(rd_ev), .empty(empty)
    );

    tgr_engine u_engine (
        .clk(clk), .rst_n(rst_n), .drag_threshold(thr_reg),
        .ev_valid(!empty), .ev(rd_ev), .ev_take(take),
        .valid(out_valid), .stall(out_stall),
        .gesture_kind(gesture_kind), .out_x(out_x), .out_y(out_y),
        .zoom_ratio(zoom_ratio), .last_result(last_result)
    );
endmodule
`default_nettype wire

>>> hw/rtl/tgr_queue.sv
// Short FIFO of accepted touch events between the front and the back part.
// Depends on tgr_pkg.
`default_nettype none
module tgr_queue
    import tgr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr_en,
    input  wire event_t wr_data,
    output logic        full,
    input  wire logic   rd_en,
    output event_t      rd_data,
    output logic        empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    event_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;

    assign full    = (cnt_reg == (AW+1)'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (rd_en)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/tgr_engine.sv
// Back part: finger tracking, iterative square root and divide, result output register.
// Depends on tgr_pkg.
`default_nettype none
module tgr_engine
    import tgr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [11:0] drag_threshold,
    input  wire logic        ev_valid,
    input  wire event_t      ev,
    output logic             ev_take,
    output logic             valid,
    input  wire logic        stall,
    output logic [2:0]       gesture_kind,
    output logic [16:0]      out_x,
    output logic [16:0]      out_y,
    output logic [15:0]      zoom_ratio,
    output logic             last_result
);
    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SQ, S_SQRT, S_DIV, S_ZOOM, S_PAN, S_EMIT
    } state_t;

    state_t state_reg;
    event_t ev_reg;
    logic [1:0]  cnt_reg;
    logic [7:0]  fid_reg, sid_reg;
    logic [15:0] fx_reg, fy_reg, sx_reg, sy_reg, px_reg, py_reg, pcx_reg, pcy_reg;
    logic        drag_reg;
    logic [16:0] base_reg;
    logic        is_move_reg;
    logic [34:0] rem_reg;
    logic [16:0] root_reg;
    logic [4:0]  it_reg;
    logic [25:0] num_reg;
    logic [24:0] drem_reg;
    logic [24:0] quo_reg;
    logic        vld_reg;
    logic [2:0]  gk_reg;
    logic [16:0] ox_reg, oy_reg;
    logic [15:0] zr_reg;
    logic        lr_reg;
    logic [16:0] dx_reg, dy_reg;
    logic [1:0]  sqph_reg;
    logic [33:0] sqa_reg;

    logic out_free;
    logic [16:0] cx, cy;
    logic [16:0] adx, ady;
    logic [25:0] dtrial;
    logic [33:0] prod;
    logic [23:0] tsq;
    logic [16:0] mx;

    assign out_free = !vld_reg || !stall;
    assign ev_take  = (state_reg == S_IDLE) && ev_valid;
    assign cx = ({1'b0, fx_reg} + {1'b0, sx_reg}) >> 1;
    assign cy = ({1'b0, fy_reg} + {1'b0, sy_reg}) >> 1;
    assign adx = dx_reg[16] ? -dx_reg : dx_reg;
    assign ady = dy_reg[16] ? -dy_reg : dy_reg;
    assign mx = (sqph_reg == 2'd0) ? adx : ady;
    assign prod = mx * mx;
    assign tsq = drag_threshold * drag_threshold;
    assign dtrial = {drem_reg, num_reg[25]} - {9'd0, base_reg};

    assign valid = vld_reg;
    assign gesture_kind = gk_reg;
    assign out_x = ox_reg;
    assign out_y = oy_reg;
    assign zoom_ratio = zr_reg;
    assign last_result = lr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            fid_reg <= '0; sid_reg <= '0;
            fx_reg <= '0; fy_reg <= '0; sx_reg <= '0; sy_reg <= '0;
            px_reg <= '0; py_reg <= '0; pcx_reg <= '0; pcy_reg <= '0;
            drag_reg <= 1'b0;
            base_reg <= '0;
            vld_reg <= 1'b0;
            ev_reg <= '0;
            is_move_reg <= 1'b0;
            rem_reg <= '0; root_reg <= '0; it_reg <= '0;
            num_reg <= '0; drem_reg <= '0; quo_reg <= '0;
            gk_reg <= '0; ox_reg <= '0; oy_reg <= '0; zr_reg <= '0; lr_reg <= 1'b0;
            dx_reg <= '0; dy_reg <= '0; sqph_reg <= '0; sqa_reg <= '0;
        end
        else
        begin
            if (vld_reg && !stall)
            begin
                vld_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (ev_valid)
                    begin
                        ev_reg <= ev;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_IDLE;
                    unique case (ev_reg.kind)
                        EV_DOWN:
                        begin
                            if (cnt_reg == 2'd0)
                            begin
                                if (out_free)
                                begin
                                    fid_reg <= ev_reg.id; fx_reg <= ev_reg.x; fy_reg <= ev_reg.y;
                                    px_reg <= ev_reg.x; py_reg <= ev_reg.y;
                                    cnt_reg <= 2'd1;
                                    vld_reg <= 1'b1; gk_reg <= G_START;
                                    ox_reg <= {1'b0, ev_reg.x}; oy_reg <= {1'b0, ev_reg.y};
                                    zr_reg <= '0; lr_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_EXEC;
                                end
                            end
                            else if (cnt_reg == 2'd1)
                            begin
                                if (ev_reg.id != fid_reg)
                                begin
                                    if (out_free)
                                    begin
                                        sid_reg <= ev_reg.id; sx_reg <= ev_reg.x; sy_reg <= ev_reg.y;
                                        cnt_reg <= 2'd2;
                                        vld_reg <= 1'b1; zr_reg <= '0; lr_reg <= 1'b1;
                                        if (drag_reg)
                                        begin
                                            gk_reg <= G_UNDO; ox_reg <= '0; oy_reg <= '0;
                                        end
                                        else
                                        begin
                                            gk_reg <= G_RELEASE;
                                            ox_reg <= {1'b0, fx_reg}; oy_reg <= {1'b0, fy_reg};
                                        end
                                        drag_reg <= 1'b0;
                                        is_move_reg <= 1'b0;
                                        dx_reg <= {1'b0, fx_reg} - {1'b0, ev_reg.x};
                                        dy_reg <= {1'b0, fy_reg} - {1'b0, ev_reg.y};
                                        sqph_reg <= '0;
                                        state_reg <= S_SQ;
                                    end
                                    else
                                    begin
                                        state_reg <= S_EXEC;
                                    end
                                end
                            end
                            else
                            begin
                                is_move_reg <= 1'b0;
                                dx_reg <= {1'b0, fx_reg} - {1'b0, sx_reg};
                                dy_reg <= {1'b0, fy_reg} - {1'b0, sy_reg};
                                sqph_reg <= '0;
                                state_reg <= S_SQ;
                            end
                        end
                        EV_MOVE:
                        begin
                            if (cnt_reg != 2'd0 && ev_reg.id == fid_reg)
                            begin
                                fx_reg <= ev_reg.x; fy_reg <= ev_reg.y;
                            end
                            if (cnt_reg == 2'd2 && ev_reg.id == sid_reg)
                            begin
                                sx_reg <= ev_reg.x; sy_reg <= ev_reg.y;
                            end
                            if (cnt_reg == 2'd1)
                            begin
                                dx_reg <= {1'b0, px_reg} - {1'b0,
                                    (ev_reg.id == fid_reg) ? ev_reg.x : fx_reg};
                                dy_reg <= {1'b0, py_reg} - {1'b0,
                                    (ev_reg.id == fid_reg) ? ev_reg.y : fy_reg};
                                sqph_reg <= '0;
                                is_move_reg <= 1'b1;
                                state_reg <= S_SQ;
                            end
                            else if (cnt_reg == 2'd2)
                            begin
                                is_move_reg <= 1'b1;
                                state_reg <= S_ZOOM;
                            end
                        end
                        EV_UP:
                        begin
                            if ((cnt_reg == 2'd1 || cnt_reg == 2'd2) && ev_reg.id == fid_reg)
                            begin
                                if (out_free)
                                begin
                                    vld_reg <= 1'b1; gk_reg <= G_RELEASE;
                                    ox_reg <= {1'b0, ev_reg.x}; oy_reg <= {1'b0, ev_reg.y};
                                    zr_reg <= '0; lr_reg <= 1'b1;
                                    if (cnt_reg == 2'd1)
                                    begin
                                        cnt_reg <= 2'd0; drag_reg <= 1'b0;
                                    end
                                    else
                                    begin
                                        fid_reg <= sid_reg; fx_reg <= sx_reg; fy_reg <= sy_reg;
                                        cnt_reg <= 2'd1;
                                    end
                                end
                                else
                                begin
                                    state_reg <= S_EXEC;
                                end
                            end
                            else if (cnt_reg == 2'd2 && ev_reg.id == sid_reg)
                            begin
                                cnt_reg <= 2'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_ZOOM:
                begin
                    // positions updated; set up distance of the pair
                    dx_reg <= {1'b0, fx_reg} - {1'b0, sx_reg};
                    dy_reg <= {1'b0, fy_reg} - {1'b0, sy_reg};
                    sqph_reg <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    sqph_reg <= sqph_reg + 2'd1;
                    if (sqph_reg == 2'd0)
                    begin
                        sqa_reg <= prod;
                    end
                    else
                    begin
                        sqph_reg <= '0;
                        if (is_move_reg && cnt_reg == 2'd1)
                        begin
                            if ({1'b0, sqa_reg} + {1'b0, prod} > {11'd0, tsq} || drag_reg)
                            begin
                                if (out_free)
                                begin
                                    drag_reg <= 1'b1;
                                    vld_reg <= 1'b1; gk_reg <= G_DRAG;
                                    ox_reg <= {1'b0, fx_reg}; oy_reg <= {1'b0, fy_reg};
                                    zr_reg <= '0; lr_reg <= 1'b1;
                                    state_reg <= S_IDLE;
                                end
                                else
                                begin
                                    sqph_reg <= 2'd1;
                                end
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            rem_reg <= {1'b0, sqa_reg} + {1'b0, prod};
                            root_reg <= '0;
                            it_reg <= 5'd17;
                            state_reg <= S_SQRT;
                        end
                    end
                end
                S_SQRT:
                begin
                    // restoring square root, one result bit per cycle
                    if (it_reg == 5'd0)
                    begin
                        if (!is_move_reg)
                        begin
                            base_reg <= root_reg;
                            pcx_reg <= cx[15:0]; pcy_reg <= cy[15:0];
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            num_reg <= {1'b0, root_reg, 8'd0};
                            drem_reg <= '0; quo_reg <= '0;
                            it_reg <= 5'd26;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                    begin
                        it_reg <= it_reg - 5'd1;
                        begin : sq_step
                            logic [35:0] r2;
                            logic [35:0] t2;
                            r2 = {1'b0, rem_reg[34:0]};
                            t2 = {17'd0, root_reg, 2'b01};
                            if ((r2 >> (2 * (it_reg - 5'd1))) >= t2)
                            begin
                                rem_reg <= 35'(r2 - (t2 << (2 * (it_reg - 5'd1))));
                                root_reg <= {root_reg[15:0], 1'b1};
                            end
                            else
                            begin
                                root_reg <= {root_reg[15:0], 1'b0};
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    if (it_reg == 5'd0)
                    begin
                        state_reg <= S_PAN;
                    end
                    else
                    begin
                        it_reg <= it_reg - 5'd1;
                        num_reg <= {num_reg[24:0], 1'b0};
                        if (!dtrial[25])
                        begin
                            drem_reg <= dtrial[24:0];
                            quo_reg <= {quo_reg[23:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[23:0], num_reg[25]};
                            quo_reg <= {quo_reg[23:0], 1'b0};
                        end
                    end
                end
                S_PAN:
                begin
                    if (out_free)
                    begin
                        vld_reg <= 1'b1; gk_reg <= G_ZOOM;
                        ox_reg <= cx; oy_reg <= cy; lr_reg <= 1'b0;
                        if (base_reg == '0 || quo_reg > 25'd65535)
                        begin
                            zr_reg <= 16'hFFFF;
                        end
                        else
                        begin
                            zr_reg <= quo_reg[15:0];
                        end
                        base_reg <= root_reg;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        vld_reg <= 1'b1; gk_reg <= G_PAN;
                        ox_reg <= cx - {1'b0, pcx_reg}; oy_reg <= cy - {1'b0, pcy_reg};
                        zr_reg <= '0; lr_reg <= 1'b1;
                        pcx_reg <= cx[15:0]; pcy_reg <= cy[15:0];
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire
